// ----- design/rgba_unpk_pkg.sv -----
// ----------------------------------------------------------------------------
// rgba_unpk_pkg
// Shared types, register indexes and arithmetic helpers for the raw image
// to RGBA unpacker.
// ----------------------------------------------------------------------------
package rgba_unpk_pkg;

    // default width of the position counters and size registers
    localparam int DIM_BITS_DEFAULT = 16;

    // configuration port geometry
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_PIXEL_FORMAT = 2'd2
    } reg_index_t;

    // source pixel formats
    typedef enum logic [1:0] {
        FMT_GRAY8 = 2'd0,
        FMT_RGB8  = 2'd1,
        FMT_CMYK8 = 2'd2,
        FMT_MONO1 = 2'd3
    } pixel_format_t;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    // floor((255-x)*(255-k)/255), divide by 255 done as add and shift
    function automatic logic [7:0] cmyk_channel(input logic [7:0] x, input logic [7:0] k);
        logic [15:0] prod;
        logic [16:0] sum;
        begin
            prod = {8'd0, CHAN_MAX - x} * {8'd0, CHAN_MAX - k};
            sum  = {1'b0, prod} + 17'd1 + {9'd0, prod[15:8]};
            return sum[15:8];
        end
    endfunction

endpackage

// ----- design/raw_image_to_rgba_unpacker_top.sv -----
// ----------------------------------------------------------------------------
// raw_image_to_rgba_unpacker_top
// Converts a raw gray8, rgb8, cmyk8 or 1-bit mono byte stream into RGBA8888
// pixels in raster order.
// ----------------------------------------------------------------------------
// A gray8, rgb8 or cmyk8 byte is taken every cycle while the output is not
// stalled; gray gives one pixel per byte, rgb one per three bytes and cmyk one
// per four. A mono byte stays in the input register until it has given one
// pixel per bit, up to eight, stopping early at a row end, so mono throughput
// is one pixel per cycle while the output is not stalled. An input byte goes
// through the input register, then the output register. After the final
// pixel of the image every further byte is taken and dropped until reset.
// m_tlast marks the last pixel that one input byte causes; m_tuser marks the
// final pixel of the image.
module raw_image_to_rgba_unpacker_top #(
    parameter int DIM_BITS = rgba_unpk_pkg::DIM_BITS_DEFAULT
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // configuration write port
    input  logic                                     cfg_we,
    input  logic [rgba_unpk_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rgba_unpk_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // byte stream in
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [7:0]                               s_tdata,   // data_byte
    // pixel stream out
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [31:0]                              m_tdata,   // red, green, blue, alpha
    output logic                                     m_tlast,   // last_of_run
    output logic                                     m_tuser    // last_pixel
);
    import rgba_unpk_pkg::*;

    // configuration registers
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;
    pixel_format_t       format_reg;

    // position and assembly state
    logic [DIM_BITS-1:0] col_reg, col_next;
    logic [DIM_BITS-1:0] row_reg, row_next;
    logic [23:0]         partial_reg, partial_next;
    logic [1:0]          phase_reg, phase_next;
    logic                done_reg, done_next;

    // input register
    logic                hold_valid_reg;
    logic [7:0]          hold_byte_reg;
    logic [2:0]          bit_reg;

    // output register
    logic                out_valid_reg;
    logic [31:0]         out_data_reg;
    logic                out_last_reg;
    logic                out_final_reg;

    // step logic
    logic                out_free;
    logic                step;
    logic                emit;
    logic                byte_done;
    logic                row_end;
    logic                img_end;
    logic [7:0]          red_next, green_next, blue_next;
    logic [DIM_BITS:0]   col_inc, row_inc;
    logic [7:0]          mono_val;
    logic [DIM_BITS+CFG_DATA_BITS-1:0] cfg_ext;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = hold_valid_reg && out_free;
    assign cfg_ext  = {{DIM_BITS{1'b0}}, cfg_data};

    // position advance for an emitted pixel
    assign col_inc = {1'b0, col_reg} + {{DIM_BITS{1'b0}}, 1'b1};
    assign row_inc = {1'b0, row_reg} + {{DIM_BITS{1'b0}}, 1'b1};
    assign mono_val = hold_byte_reg[bit_reg] ? CHAN_MAX : 8'd0;

    // per-step pixel decode and state update
    always_comb
    begin
        emit         = 1'b0;
        red_next     = hold_byte_reg;
        green_next   = hold_byte_reg;
        blue_next    = hold_byte_reg;
        partial_next = partial_reg;
        phase_next   = phase_reg;
        case (format_reg)
            FMT_GRAY8:
            begin
                emit = 1'b1;
            end
            FMT_RGB8:
            begin
                if (phase_reg inside {2'd2, 2'd3})
                begin
                    emit       = 1'b1;
                    red_next   = partial_reg[7:0];
                    green_next = partial_reg[15:8];
                    phase_next = 2'd0;
                end
                else
                begin
                    if (phase_reg == 2'd0)
                        partial_next[7:0] = hold_byte_reg;
                    else
                        partial_next[15:8] = hold_byte_reg;
                    phase_next = phase_reg + 2'd1;
                end
            end
            FMT_CMYK8:
            begin
                if (phase_reg == 2'd3)
                begin
                    emit       = 1'b1;
                    red_next   = cmyk_channel(partial_reg[7:0], hold_byte_reg);
                    green_next = cmyk_channel(partial_reg[15:8], hold_byte_reg);
                    blue_next  = cmyk_channel(partial_reg[23:16], hold_byte_reg);
                    phase_next = 2'd0;
                end
                else
                begin
                    case (phase_reg)
                        2'd0:    partial_next[7:0]   = hold_byte_reg;
                        2'd1:    partial_next[15:8]  = hold_byte_reg;
                        default: partial_next[23:16] = hold_byte_reg;
                    endcase
                    phase_next = phase_reg + 2'd1;
                end
            end
            default:
            begin
                emit       = 1'b1;
                red_next   = mono_val;
                green_next = mono_val;
                blue_next  = mono_val;
            end
        endcase

        // nothing happens once the image is complete
        if (done_reg)
        begin
            emit         = 1'b0;
            partial_next = partial_reg;
            phase_next   = phase_reg;
        end

        row_end  = emit && (col_inc >= {1'b0, width_reg});
        img_end  = row_end && (row_inc >= {1'b0, height_reg});
        col_next = col_reg;
        row_next = row_reg;
        done_next = done_reg;
        if (emit)
        begin
            if (row_end)
            begin
                col_next = '0;
                if (img_end)
                begin
                    row_next  = '0;
                    done_next = 1'b1;
                end
                else
                begin
                    row_next = row_inc[DIM_BITS-1:0];
                end
            end
            else
            begin
                col_next = col_inc[DIM_BITS-1:0];
            end
        end

        // a mono byte keeps stepping until its last bit or a row end
        byte_done = done_reg || (format_reg != FMT_MONO1) || (bit_reg == 3'd0) || row_end;
    end

    assign s_tready = !hold_valid_reg || (step && byte_done);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= {{(DIM_BITS-1){1'b0}}, 1'b1};
            height_reg <= {{(DIM_BITS-1){1'b0}}, 1'b1};
            format_reg <= FMT_RGB8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_ext[DIM_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_ext[DIM_BITS-1:0];
                REG_PIXEL_FORMAT: format_reg <= pixel_format_t'(cfg_data[1:0]);
                default:          ;
            endcase
        end
    end

    // position and assembly state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            partial_reg <= '0;
            phase_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else if (step)
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            partial_reg <= partial_next;
            phase_reg   <= phase_next;
            done_reg    <= done_next;
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (s_tready)
            hold_valid_reg <= s_tvalid;
    end

    // input register payload and mono bit pointer
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            hold_byte_reg <= s_tdata;
            bit_reg       <= 3'd7;
        end
        else if (step && !byte_done)
        begin
            bit_reg <= bit_reg - 3'd1;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= step && emit;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_data_reg  <= {CHAN_MAX, blue_next, green_next, red_next};
            out_last_reg  <= byte_done;
            out_final_reg <= img_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_final_reg;

endmodule
